// ----- rtl/page_frame_pool_replacement_macros.svh -----
// Assertion macros for the page frame pool.
`ifndef PAGE_FRAME_POOL_REPLACEMENT_MACROS_SVH
`define PAGE_FRAME_POOL_REPLACEMENT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PFP_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error(msg);
// Next-cycle implication.
`define PFP_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error(msg);
`endif

// ----- rtl/pfp_pkg.sv -----
// Package: types and codes shared by the page frame pool.
package pfp_pkg;
  localparam int unsigned OP_W = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned PIN_W = 16;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned STAMP_W = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 25;
  localparam int unsigned FIU_W = 5;
  localparam int unsigned IDX_OUT_W = 4;
  localparam int unsigned OUT_PAGE_W = 24;
  localparam int unsigned MAX_OUT = 16;

  typedef enum logic [OP_W-1:0] {
    OP_PIN = 3'd0, OP_UNPIN = 3'd1, OP_DIRTY = 3'd2, OP_FORCE = 3'd3,
    OP_FLUSH = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK = 2'd0, ST_NOT_RES = 2'd1, ST_BEYOND = 2'd2, ST_NO_FREE = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRATEGY = 2'd0, CFG_FRAMES = 2'd1, CFG_FILE_PAGES = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_APPLY, S_FLUSH, S_EMIT
  } state_e;

  // Per-frame view handed from the frame table to the scanner.
  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic             tag_eq;
    logic [PIN_W-1:0] pins;
    logic [STAMP_W-1:0] stamp;
  } frame_view_t;
endpackage

// ----- rtl/pfp_if.sv -----
// Valid/ready channel interfaces for requests and results.
interface pfp_req_if #(parameter int unsigned PAGE_BITS = 24);
  logic                    valid;
  logic                    ready;
  logic [pfp_pkg::OP_W-1:0] operation;
  logic [PAGE_BITS-1:0]    page_number;
  modport source (output valid, operation, page_number, input ready);
  modport sink (input valid, operation, page_number, output ready);
endinterface

interface pfp_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [pfp_pkg::STAT_W-1:0]      status;
  logic [pfp_pkg::IDX_OUT_W-1:0]   frame_index;
  logic                            write_back;
  logic [pfp_pkg::OUT_PAGE_W-1:0]  write_back_page;
  logic                            read_from_disk;
  logic [pfp_pkg::PIN_W-1:0]       pin_count_after;
  logic [pfp_pkg::CNT_W-1:0]       reads_total;
  logic [pfp_pkg::CNT_W-1:0]       writes_total;
  logic                            last;
  modport source (output valid, status, frame_index, write_back, write_back_page,
                  read_from_disk, pin_count_after, reads_total, writes_total, last,
                  input ready);
  modport sink (input valid, status, frame_index, write_back, write_back_page,
                read_from_disk, pin_count_after, reads_total, writes_total, last,
                output ready);
endinterface

// ----- rtl/pfp_scan.sv -----
// Shared compare unit: one frame per cycle for hit, empty and victim search.
module pfp_scan #(
  parameter int unsigned NUM_FRAMES = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  step_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  pfp_pkg::frame_view_t  view_i,
  output logic                  hit_o,
  output logic [IDX_W-1:0]      hit_idx_o,
  output logic                  empty_o,
  output logic [IDX_W-1:0]      empty_idx_o,
  output logic                  cand_o,
  output logic [IDX_W-1:0]      cand_idx_o
);
  logic hit_q, hit_d, empty_q, empty_d, cand_q, cand_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d, empty_idx_q, empty_idx_d;
  logic [IDX_W-1:0] cand_idx_q, cand_idx_d;
  logic [pfp_pkg::STAMP_W-1:0] best_q, best_d;

  always_comb begin
    hit_d = hit_q; hit_idx_d = hit_idx_q;
    empty_d = empty_q; empty_idx_d = empty_idx_q;
    cand_d = cand_q; cand_idx_d = cand_idx_q; best_d = best_q;
    if (start_i) begin
      hit_d = 1'b0; empty_d = 1'b0; cand_d = 1'b0;
    end else if (step_i) begin
      if (!hit_q && view_i.valid && view_i.tag_eq) begin
        hit_d = 1'b1; hit_idx_d = idx_i;
      end
      if (!empty_q && !view_i.valid) begin
        empty_d = 1'b1; empty_idx_d = idx_i;
      end
      // one 64-bit compare, reused every cycle
      if (view_i.valid && view_i.pins == '0 && (!cand_q || view_i.stamp < best_q)) begin
        cand_d = 1'b1; cand_idx_d = idx_i; best_d = view_i.stamp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0; empty_q <= 1'b0; cand_q <= 1'b0;
    end else begin
      hit_q <= hit_d; empty_q <= empty_d; cand_q <= cand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q <= hit_idx_d; empty_idx_q <= empty_idx_d;
    cand_idx_q <= cand_idx_d; best_q <= best_d;
  end

  assign hit_o = hit_q;
  assign hit_idx_o = hit_idx_q;
  assign empty_o = empty_q;
  assign empty_idx_o = empty_idx_q;
  assign cand_o = cand_q;
  assign cand_idx_o = cand_idx_q;
endmodule

// ----- rtl/page_frame_pool_replacement.sv -----
// Top level: page frame table, scan sequencer and result register.
//
//  channel | dir | handshake     | word
//  req     | in  | valid/ready   | operation, page_number
//  rsp     | out | valid/ready   | status .. last (one word per result)
//  cfg     | in  | cfg_we_i      | cfg_idx_i, cfg_data_i
//
// Steps: a pin/unpin/dirty/force is accepted, scans the active frames,
// applies and then outputs its word; the single compare unit in pfp_scan
// visits one frame per cycle. Reserved codes are taken and give no word.
// Flush visits one frame per cycle while no dirty, unpinned frame waits
// on the result register; each write-back word is held until the next dirty
// frame or the end of the scan shows whether it is last, then waits on
// the output until taken. Output stalls hold the sequence back.
// Reset clears valid, dirty, pins, stamps and counters at once; tags are
// not reset. req_ready is low while a request or its result is in flight.
`include "page_frame_pool_replacement_macros.svh"
module page_frame_pool_replacement #(
  parameter int unsigned NUM_FRAMES = 16,
  parameter int unsigned PAGE_BITS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  pfp_req_if.sink   req,
  pfp_rsp_if.source rsp,
  input  logic                             cfg_we_i,
  input  logic [pfp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pfp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  localparam int unsigned IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned CNT_IW = $clog2(NUM_FRAMES + 1);
  localparam int unsigned FLUSH_CW = $clog2(pfp_pkg::MAX_OUT + 1);

  // frame table, held in flops (each entry at its own index)
  logic [PAGE_BITS-1:0]           tag_q [NUM_FRAMES];
  logic [NUM_FRAMES-1:0]          valid_q, dirty_q;
  logic [pfp_pkg::PIN_W-1:0]      pins_q [NUM_FRAMES];
  logic [pfp_pkg::STAMP_W-1:0]    rec_q [NUM_FRAMES];
  logic [pfp_pkg::STAMP_W-1:0]    arr_q [NUM_FRAMES];
  logic [pfp_pkg::STAMP_W-1:0]    clock_q;
  logic [pfp_pkg::CNT_W-1:0]      rd_cnt_q, wr_cnt_q;

  logic                            strat_q;
  logic [pfp_pkg::FIU_W-1:0]       fiu_q;
  logic [pfp_pkg::CFG_DATA_W-1:0]  fpc_q;

  pfp_pkg::state_e state_q, state_d;
  logic [pfp_pkg::OP_W-1:0] op_q;
  logic [PAGE_BITS-1:0]     page_q;
  logic [IDX_W-1:0]         idx_q;
  logic [CNT_IW-1:0]        nact_q;
  logic [FLUSH_CW-1:0]      fcnt_q;

  // result register; hold_q: flush word loaded but not yet shown
  logic                           ov_q;
  logic                           hold_q;
  logic [pfp_pkg::STAT_W-1:0]     o_st_q;
  logic [IDX_W-1:0]               o_fi_q;
  logic                           o_wb_q, o_rd_q, o_last_q;
  logic [PAGE_BITS-1:0]           o_wbp_q;
  logic [pfp_pkg::PIN_W-1:0]      o_pin_q;

  // active frame count, clamped to 1..NUM_FRAMES
  logic [CNT_IW-1:0] nact;
  always_comb begin
    if (fiu_q == '0) nact = CNT_IW'(1);
    else if (32'(fiu_q) > NUM_FRAMES) nact = CNT_IW'(NUM_FRAMES);
    else nact = CNT_IW'(fiu_q);
  end

  logic req_fire, rsp_fire, idx_end;
  assign req_fire = req.valid && req.ready;
  assign rsp_fire = rsp.valid && rsp.ready;
  assign idx_end = (CNT_IW'(idx_q) + CNT_IW'(1)) >= nact_q;

  pfp_pkg::frame_view_t view;
  always_comb begin
    view.valid  = valid_q[idx_q];
    view.dirty  = dirty_q[idx_q];
    view.tag_eq = tag_q[idx_q] == page_q;
    view.pins   = pins_q[idx_q];
    view.stamp  = strat_q ? rec_q[idx_q] : arr_q[idx_q];
  end

  logic scan_start, scan_step;
  logic hit, empty, cand;
  logic [IDX_W-1:0] hit_idx, empty_idx, cand_idx;
  assign scan_start = req_fire;
  assign scan_step = state_q == pfp_pkg::S_SCAN;

  pfp_scan #(.NUM_FRAMES(NUM_FRAMES), .IDX_W(IDX_W)) u_scan (
    .clk_i, .rst_ni, .start_i(scan_start), .step_i(scan_step), .idx_i(idx_q),
    .view_i(view), .hit_o(hit), .hit_idx_o(hit_idx), .empty_o(empty),
    .empty_idx_o(empty_idx), .cand_o(cand), .cand_idx_o(cand_idx)
  );

  // flush: a dirty, unpinned frame is loaded once the register is free and
  // nothing is held; a second one first releases the held word (not last)
  logic flush_take, fl_load, fl_adv;
  assign flush_take = view.valid && view.dirty && view.pins == '0;
  assign fl_load = flush_take && !hold_q && (!ov_q || rsp_fire);
  assign fl_adv = fl_load || !flush_take;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfp_pkg::S_IDLE: begin
        if (req_fire) begin
          if (req.operation == pfp_pkg::OP_FLUSH) state_d = pfp_pkg::S_FLUSH;
          else if (req.operation == pfp_pkg::OP_PIN ||
                   req.operation == pfp_pkg::OP_UNPIN ||
                   req.operation == pfp_pkg::OP_DIRTY ||
                   req.operation == pfp_pkg::OP_FORCE) state_d = pfp_pkg::S_SCAN;
        end
      end
      pfp_pkg::S_SCAN:  if (idx_end) state_d = pfp_pkg::S_APPLY;
      pfp_pkg::S_APPLY: state_d = pfp_pkg::S_EMIT;
      pfp_pkg::S_FLUSH: begin
        if (fl_adv && (idx_end ||
            (fl_load && fcnt_q == FLUSH_CW'(pfp_pkg::MAX_OUT - 1))))
          state_d = pfp_pkg::S_EMIT;
      end
      pfp_pkg::S_EMIT:  if (rsp_fire) state_d = pfp_pkg::S_IDLE;
      default: state_d = pfp_pkg::S_IDLE;
    endcase
  end

  // outputs
  assign req.ready = state_q == pfp_pkg::S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= pfp_pkg::S_IDLE;
    else state_q <= state_d;
  end

  logic [IDX_W-1:0] vic;
  logic beyond;
  assign vic = empty ? empty_idx : cand_idx;
  assign beyond = {1'b0, page_q} >= fpc_q;

  // datapath and table updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0; dirty_q <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        pins_q[i] <= '0; rec_q[i] <= '0; arr_q[i] <= '0;
      end
      clock_q <= '0; rd_cnt_q <= '0; wr_cnt_q <= '0;
      strat_q <= 1'b0; fiu_q <= pfp_pkg::FIU_W'(16); fpc_q <= '0;
      ov_q <= 1'b0; hold_q <= 1'b0; fcnt_q <= '0; idx_q <= '0; nact_q <= '0;
      o_st_q <= pfp_pkg::ST_OK; o_fi_q <= '0; o_wb_q <= 1'b0; o_rd_q <= 1'b0;
      o_last_q <= 1'b0; o_wbp_q <= '0; o_pin_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pfp_pkg::CFG_STRATEGY:   strat_q <= cfg_data_i[0];
          pfp_pkg::CFG_FRAMES:     fiu_q <= cfg_data_i[pfp_pkg::FIU_W-1:0];
          pfp_pkg::CFG_FILE_PAGES: fpc_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (rsp_fire) ov_q <= 1'b0;
      unique case (state_q)
        pfp_pkg::S_IDLE: begin
          idx_q <= '0; fcnt_q <= '0; nact_q <= nact; hold_q <= 1'b0;
        end
        pfp_pkg::S_SCAN: idx_q <= idx_q + IDX_W'(1);
        pfp_pkg::S_APPLY: begin
          ov_q <= 1'b1; o_last_q <= 1'b1; o_wb_q <= 1'b0; o_wbp_q <= '0;
          o_rd_q <= 1'b0; o_st_q <= pfp_pkg::ST_OK; o_fi_q <= '0; o_pin_q <= '0;
          if (op_q == pfp_pkg::OP_PIN) begin
            if (beyond) o_st_q <= pfp_pkg::ST_BEYOND;
            else if (hit) begin
              if (pins_q[hit_idx] != '1) pins_q[hit_idx] <= pins_q[hit_idx] + 1'b1;
              o_pin_q <= (pins_q[hit_idx] != '1) ? pins_q[hit_idx] + 1'b1 : pins_q[hit_idx];
              clock_q <= clock_q + 1'b1;
              rec_q[hit_idx] <= clock_q + 1'b1;
              o_fi_q <= hit_idx;
            end else if (!empty && !cand) o_st_q <= pfp_pkg::ST_NO_FREE;
            else begin
              if (valid_q[vic] && dirty_q[vic]) begin
                o_wb_q <= 1'b1; o_wbp_q <= tag_q[vic];
                wr_cnt_q <= wr_cnt_q + 1'b1;
              end
              rd_cnt_q <= rd_cnt_q + 1'b1;
              clock_q <= clock_q + 1'b1;
              valid_q[vic] <= 1'b1; dirty_q[vic] <= 1'b0; pins_q[vic] <= 16'd1;
              rec_q[vic] <= clock_q + 1'b1; arr_q[vic] <= clock_q + 1'b1;
              o_rd_q <= 1'b1; o_pin_q <= 16'd1; o_fi_q <= vic;
            end
          end else if (!hit) o_st_q <= pfp_pkg::ST_NOT_RES;
          else begin
            o_fi_q <= hit_idx; o_pin_q <= pins_q[hit_idx];
            if (op_q == pfp_pkg::OP_UNPIN) begin
              if (pins_q[hit_idx] != '0) begin
                pins_q[hit_idx] <= pins_q[hit_idx] - 1'b1;
                o_pin_q <= pins_q[hit_idx] - 1'b1;
              end
            end else if (op_q == pfp_pkg::OP_DIRTY) dirty_q[hit_idx] <= 1'b1;
            else if (dirty_q[hit_idx]) begin
              o_wb_q <= 1'b1; o_wbp_q <= tag_q[hit_idx];
              dirty_q[hit_idx] <= 1'b0; wr_cnt_q <= wr_cnt_q + 1'b1;
            end
          end
        end
        pfp_pkg::S_FLUSH: begin
          if (flush_take && hold_q) begin
            // another dirty frame follows, so the held word is not last
            ov_q <= 1'b1; hold_q <= 1'b0;
          end else if (fl_load) begin
            idx_q <= idx_q + IDX_W'(1);
            dirty_q[idx_q] <= 1'b0; wr_cnt_q <= wr_cnt_q + 1'b1;
            fcnt_q <= fcnt_q + FLUSH_CW'(1);
            hold_q <= 1'b1; o_st_q <= pfp_pkg::ST_OK; o_fi_q <= idx_q;
            o_wb_q <= 1'b1; o_wbp_q <= tag_q[idx_q]; o_rd_q <= 1'b0;
            o_pin_q <= '0; o_last_q <= 1'b0;
          end else if (!flush_take) idx_q <= idx_q + IDX_W'(1);
        end
        pfp_pkg::S_EMIT: begin
          // flush end: show the held word as last, or give the empty result
          if (op_q == pfp_pkg::OP_FLUSH && !ov_q) begin
            ov_q <= 1'b1; o_last_q <= 1'b1; hold_q <= 1'b0;
            if (!hold_q) begin
              o_st_q <= pfp_pkg::ST_OK; o_fi_q <= '0; o_wb_q <= 1'b0;
              o_wbp_q <= '0; o_rd_q <= 1'b0; o_pin_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q <= req.operation; page_q <= req.page_number;
    end
    if (state_q == pfp_pkg::S_APPLY && op_q == pfp_pkg::OP_PIN && !beyond && !hit &&
        (empty || cand)) tag_q[vic] <= page_q;
  end

  // EMIT holds until the final word is taken, so no request is accepted
  // while a result is still waiting.
  assign rsp.valid = ov_q;
  assign rsp.status = o_st_q;
  assign rsp.frame_index = pfp_pkg::IDX_OUT_W'(o_fi_q);
  assign rsp.write_back = o_wb_q;
  assign rsp.write_back_page = pfp_pkg::OUT_PAGE_W'(o_wbp_q);
  assign rsp.read_from_disk = o_rd_q;
  assign rsp.pin_count_after = o_pin_q;
  assign rsp.reads_total = rd_cnt_q;
  assign rsp.writes_total = wr_cnt_q;
  assign rsp.last = o_last_q;

  `PFP_ASSERT_IMP(a_busy_not_ready, clk_i, rst_ni, state_q != pfp_pkg::S_IDLE, !req.ready,
    "request accepted while busy")
  `PFP_ASSERT_NXT(a_apply_emits, clk_i, rst_ni, state_q == pfp_pkg::S_APPLY, ov_q && o_last_q,
    "apply produced no final word")
  `PFP_ASSERT_IMP(a_rd_has_pin, clk_i, rst_ni, ov_q && o_rd_q,
    o_pin_q == 16'd1 && o_st_q == pfp_pkg::ST_OK, "read without fresh pin")
  `PFP_ASSERT_NXT(a_hold_stall, clk_i, rst_ni, ov_q && !rsp.ready, ov_q && $stable(o_fi_q),
    "result dropped under stall")
  `PFP_ASSERT_IMP(a_hold_hidden, clk_i, rst_ni, hold_q, !ov_q,
    "held flush word shown early")
endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the page frame pool with FIFO/LRU replacement.

typedef struct {
  logic [pfp_pkg::STAT_W-1:0]     status;
  logic [pfp_pkg::IDX_OUT_W-1:0]  frame_index;
  logic                           write_back;
  logic [pfp_pkg::OUT_PAGE_W-1:0] write_back_page;
  logic                           read_from_disk;
  logic [pfp_pkg::PIN_W-1:0]      pin_count_after;
  logic [pfp_pkg::CNT_W-1:0]      reads_total;
  logic [pfp_pkg::CNT_W-1:0]      writes_total;
  logic                           last;
} pool_word_t;

class pool_scoreboard;
  localparam int FRAMES = 16;
  pool_word_t                 pending_words[$];
  int                         errors;
  logic [23:0]                tag[FRAMES];
  bit                         valid[FRAMES];
  bit                         dirty[FRAMES];
  logic [pfp_pkg::PIN_W-1:0]  pins[FRAMES];
  logic [63:0]                recency[FRAMES];
  logic [63:0]                arrival[FRAMES];
  logic [63:0]                stamp_now;
  logic [pfp_pkg::CNT_W-1:0]  reads;
  logic [pfp_pkg::CNT_W-1:0]  writes;
  bit                         use_lru;
  logic [4:0]                 frame_limit;
  logic [24:0]                file_pages;

  function new();
    errors = 0;
    for (int i = 0; i < FRAMES; i++) begin
      tag[i] = '0; valid[i] = 0; dirty[i] = 0; pins[i] = '0;
      recency[i] = '0; arrival[i] = '0;
    end
    stamp_now = '0; reads = '0; writes = '0;
    use_lru = 0; frame_limit = 5'd16; file_pages = '0;
  endfunction

  function void set_reg(pfp_pkg::cfg_idx_e idx, logic [pfp_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      pfp_pkg::CFG_STRATEGY:   use_lru = d[0];
      pfp_pkg::CFG_FRAMES:     frame_limit = d[4:0];
      pfp_pkg::CFG_FILE_PAGES: file_pages = d;
      default: ;
    endcase
  endfunction

  function void push(logic [1:0] st, int f, bit wb, logic [23:0] wbp, bit rd,
                     logic [pfp_pkg::PIN_W-1:0] p, bit lst);
    pool_word_t w;
    w.status = st; w.frame_index = f[3:0]; w.write_back = wb;
    w.write_back_page = wbp; w.read_from_disk = rd; w.pin_count_after = p;
    w.reads_total = reads; w.writes_total = writes; w.last = lst;
    pending_words.push_back(w);
  endfunction

  // Compute the words one accepted request causes and queue them.
  function void note_request(logic [pfp_pkg::OP_W-1:0] op, logic [23:0] page);
    int n, f, k, best;
    logic [63:0] best_v, v;
    bit wb;
    logic [23:0] wbp;
    n = (frame_limit == 0) ? 1 : (frame_limit > FRAMES) ? FRAMES : frame_limit;
    f = -1;
    if (op != pfp_pkg::OP_FLUSH)
      for (int i = 0; i < n; i++)
        if (f < 0 && valid[i] && tag[i] == page) f = i;
    case (op)
      pfp_pkg::OP_PIN: begin
        if ({1'b0, page} >= file_pages) begin
          push(pfp_pkg::ST_BEYOND, 0, 0, '0, 0, '0, 1);
        end else if (f >= 0) begin
          if (pins[f] != 16'hFFFF) pins[f]++;
          stamp_now++;
          recency[f] = stamp_now;
          push(pfp_pkg::ST_OK, f, 0, '0, 0, pins[f], 1);
        end else begin
          best = -1; best_v = '0;
          for (int i = 0; i < n; i++)
            if (best < 0 && !valid[i]) best = i;
          if (best < 0)
            for (int i = 0; i < n; i++) begin
              v = use_lru ? recency[i] : arrival[i];
              if (pins[i] == 0 && (best < 0 || v < best_v)) begin
                best = i; best_v = v;
              end
            end
          if (best < 0) begin
            push(pfp_pkg::ST_NO_FREE, 0, 0, '0, 0, '0, 1);
          end else begin
            wb = valid[best] && dirty[best];
            wbp = wb ? tag[best] : '0;
            if (wb) writes++;
            reads++;
            stamp_now++;
            tag[best] = page; valid[best] = 1; dirty[best] = 0; pins[best] = 1;
            recency[best] = stamp_now; arrival[best] = stamp_now;
            push(pfp_pkg::ST_OK, best, wb, wbp, 1, 16'd1, 1);
          end
        end
      end
      pfp_pkg::OP_UNPIN, pfp_pkg::OP_DIRTY, pfp_pkg::OP_FORCE: begin
        if (f < 0) begin
          push(pfp_pkg::ST_NOT_RES, 0, 0, '0, 0, '0, 1);
        end else if (op == pfp_pkg::OP_UNPIN) begin
          if (pins[f] != 0) pins[f]--;
          push(pfp_pkg::ST_OK, f, 0, '0, 0, pins[f], 1);
        end else if (op == pfp_pkg::OP_DIRTY) begin
          dirty[f] = 1;
          push(pfp_pkg::ST_OK, f, 0, '0, 0, pins[f], 1);
        end else begin
          wb = dirty[f];
          wbp = wb ? tag[f] : '0;
          if (wb) begin
            dirty[f] = 0; writes++;
          end
          push(pfp_pkg::ST_OK, f, wb, wbp, 0, pins[f], 1);
        end
      end
      pfp_pkg::OP_FLUSH: begin
        k = 0;
        for (int i = 0; i < n && k < pfp_pkg::MAX_OUT; i++)
          if (valid[i] && dirty[i] && pins[i] == 0) begin
            dirty[i] = 0; writes++;
            push(pfp_pkg::ST_OK, i, 1, tag[i], 0, '0, 0);
            k++;
          end
        if (k == 0) push(pfp_pkg::ST_OK, 0, 0, '0, 0, '0, 1);
        else pending_words[$].last = 1;
      end
      default: ;  // reserved codes: no word
    endcase
  endfunction

  function void compare(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      errors++;
    end
  endfunction

  function void check_result(pool_word_t got);
    pool_word_t e;
    if (pending_words.size() == 0) begin
      $error("unexpected result word, frame %0d", got.frame_index);
      errors++;
      return;
    end
    e = pending_words.pop_front();
    compare("status", e.status, got.status);
    compare("frame_index", e.frame_index, got.frame_index);
    compare("write_back", e.write_back, got.write_back);
    compare("write_back_page", e.write_back_page, got.write_back_page);
    compare("read_from_disk", e.read_from_disk, got.read_from_disk);
    compare("pin_count_after", e.pin_count_after, got.pin_count_after);
    compare("reads_total", e.reads_total, got.reads_total);
    compare("writes_total", e.writes_total, got.writes_total);
    compare("last", e.last, got.last);
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Idle this many cycles before a register write so the pool is back in idle.
  localparam int SETTLE_CYCLES = 40;
  // Longest legal quiet spell is a flush word under heavy stall; far below.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [pfp_pkg::OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [pfp_pkg::OP_W-1:0] OP_RSVD_LAST = 3'd7;
  localparam logic [pfp_pkg::CFG_DATA_W-1:0] FULL_FILE = 25'd16777216;
  localparam int PHASE_ITEMS = 38;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [pfp_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [pfp_pkg::CFG_DATA_W-1:0] cfg_data_i;

  pfp_req_if #(.PAGE_BITS(24)) req_ch ();
  pfp_rsp_if rsp_ch ();

  page_frame_pool_replacement #(.NUM_FRAMES(16), .PAGE_BITS(24)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req_ch), .rsp(rsp_ch),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  pool_scoreboard pool_model = new();
  int sender_gap_pct = 0;
  int receiver_stall_pct = 0;
  int idle_count = 0;
  int requests_sent = 0;
  int words_seen = 0;
  logic [23:0] page_pool[12];

  // Receiver: random stall with the current percentage.
  always @(posedge clk_i)
    rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);

  // Monitors: sample at the edge, before any update of this step lands.
  always @(posedge clk_i) begin
    pool_word_t w;
    if (rst_ni && req_ch.valid && req_ch.ready) begin
      pool_model.note_request(req_ch.operation, req_ch.page_number);
      requests_sent++;
    end
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      w.status = rsp_ch.status; w.frame_index = rsp_ch.frame_index;
      w.write_back = rsp_ch.write_back; w.write_back_page = rsp_ch.write_back_page;
      w.read_from_disk = rsp_ch.read_from_disk;
      w.pin_count_after = rsp_ch.pin_count_after;
      w.reads_total = rsp_ch.reads_total; w.writes_total = rsp_ch.writes_total;
      w.last = rsp_ch.last;
      pool_model.check_result(w);
      words_seen++;
    end
  end

  // Watchdog: cycles with no word moving on either channel.
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // Send one request word; valid stays high into the next call unless a gap
  // is drawn, so back-to-back words never toggle valid within a step.
  task automatic send_request(logic [pfp_pkg::OP_W-1:0] op, logic [23:0] page);
    while ($urandom_range(99) < sender_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.operation <= op;
    req_ch.page_number <= page;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // Register write only once the pool has drained and settled.
  task automatic write_reg(pfp_pkg::cfg_idx_e idx, logic [pfp_pkg::CFG_DATA_W-1:0] d);
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pool_model.pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    pool_model.set_reg(idx, d);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly well-formed traffic on a small page set so hits, evictions and
  // flushes happen; some full-range pages and reserved codes mixed in.
  task automatic random_phase(int count, logic [pfp_pkg::CFG_DATA_W-1:0] file_size);
    int r;
    logic [23:0] page;
    logic [pfp_pkg::OP_W-1:0] op;
    for (int i = 0; i < 12; i++)
      page_pool[i] = (file_size <= 25'd64) ? 24'($urandom_range(63)) : 24'($urandom);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      page = ($urandom_range(99) < 88) ? page_pool[$urandom_range(11)] : 24'($urandom);
      if (r < 40) op = pfp_pkg::OP_PIN;
      else if (r < 55) op = pfp_pkg::OP_UNPIN;
      else if (r < 68) op = pfp_pkg::OP_DIRTY;
      else if (r < 79) op = pfp_pkg::OP_FORCE;
      else if (r < 88) op = pfp_pkg::OP_FLUSH;
      else if (r < 92) op = OP_RSVD_FIRST + pfp_pkg::OP_W'($urandom_range(2));
      else op = pfp_pkg::OP_PIN;
      send_request(op, page);
      if (op >= OP_RSVD_FIRST && op <= OP_RSVD_LAST) i--;  // ignored words don't count
    end
  endtask

  initial begin
    req_ch.valid <= 1'b0;
    req_ch.operation <= pfp_pkg::OP_PIN;
    req_ch.page_number <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= pfp_pkg::CFG_STRATEGY;
    cfg_data_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset config first (empty file, so any pin is beyond file).
    send_request(pfp_pkg::OP_PIN, 24'd0);
    write_reg(pfp_pkg::CFG_FILE_PAGES, FULL_FILE);
    write_reg(pfp_pkg::CFG_STRATEGY, 25'd1);
    write_reg(pfp_pkg::CFG_FRAMES, 25'd4);
    send_request(pfp_pkg::OP_PIN, 24'd0);
    send_request(pfp_pkg::OP_PIN, 24'hFFFFFF);
    send_request(pfp_pkg::OP_PIN, 24'd5);
    send_request(pfp_pkg::OP_PIN, 24'd7);
    send_request(pfp_pkg::OP_PIN, 24'd9);          // every frame pinned
    send_request(pfp_pkg::OP_UNPIN, 24'd3);        // not resident
    send_request(pfp_pkg::OP_DIRTY, 24'd0);
    send_request(pfp_pkg::OP_DIRTY, 24'hFFFFFF);
    send_request(pfp_pkg::OP_FORCE, 24'd0);        // dirty and pinned: still written
    send_request(pfp_pkg::OP_FORCE, 24'd0);        // now clean
    send_request(pfp_pkg::OP_UNPIN, 24'd0);
    send_request(pfp_pkg::OP_UNPIN, 24'd0);        // unpin at zero
    send_request(pfp_pkg::OP_FLUSH, 24'h123456);   // nothing dirty and unpinned
    send_request(pfp_pkg::OP_DIRTY, 24'd0);
    send_request(pfp_pkg::OP_FLUSH, 24'd0);
    send_request(pfp_pkg::OP_DIRTY, 24'd0);
    send_request(pfp_pkg::OP_PIN, 24'd9);          // evicts the only unpinned frame
    send_request(OP_RSVD_FIRST, 24'd9);
    send_request(OP_RSVD_FIRST + 3'd1, 24'd9);
    send_request(OP_RSVD_LAST, 24'd9);
    send_request(pfp_pkg::OP_PIN, 24'd9);

    // One-frame pool: repeated pins on one page, then unpin and flush.
    write_reg(pfp_pkg::CFG_FRAMES, 25'd1);
    for (int i = 0; i < 3; i++) send_request(pfp_pkg::OP_PIN, 24'd3);
    send_request(pfp_pkg::OP_UNPIN, 24'd3);
    send_request(pfp_pkg::OP_FLUSH, 24'd0);

    // Random phases across idling modes and register settings.
    write_reg(pfp_pkg::CFG_STRATEGY, 25'd0);
    write_reg(pfp_pkg::CFG_FRAMES, 25'd16);
    random_phase(PHASE_ITEMS, FULL_FILE);

    sender_gap_pct = 59;
    write_reg(pfp_pkg::CFG_STRATEGY, 25'd1);
    write_reg(pfp_pkg::CFG_FRAMES, 25'd0);         // acts as one frame
    write_reg(pfp_pkg::CFG_FILE_PAGES, 25'd40);
    random_phase(PHASE_ITEMS, 25'd40);

    sender_gap_pct = 0;
    receiver_stall_pct = 59;
    write_reg(pfp_pkg::CFG_FRAMES, 25'd31);        // clamps to all frames
    write_reg(pfp_pkg::CFG_FILE_PAGES, FULL_FILE);
    random_phase(PHASE_ITEMS, FULL_FILE);

    sender_gap_pct = 28;
    receiver_stall_pct = 28;
    write_reg(pfp_pkg::CFG_STRATEGY, 25'd0);
    write_reg(pfp_pkg::CFG_FRAMES, 25'd5);
    write_reg(pfp_pkg::CFG_FILE_PAGES, 25'd24);
    random_phase(PHASE_ITEMS, 25'd24);

    req_ch.valid <= 1'b0;
    while (pool_model.pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests and %0d result words: FIFO and LRU, pool sizes",
             requests_sent, words_seen);
    $display("0/1/4/5/16/31, file limits, evictions, flushes and idling mixes.");
    if (pool_model.errors == 0 && pool_model.pending_words.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/pfp_pkg.sv
rtl/pfp_if.sv
rtl/pfp_scan.sv
rtl/page_frame_pool_replacement.sv
bench/testbench.sv
